@@ rtl/lebd_pkg.sv @@
// Shared types, constants and helpers for the label edge depth blanker.
package lebd_pkg;

    localparam int LABEL_W   = 24;
    localparam int DEPTH_W   = 16;
    localparam int ROW_W     = 10;
    localparam int OUT_COL_W = 10;
    localparam int CFG_W     = 11;
    localparam int IDX_W     = 2;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;
    localparam int SUM_W     = 10;

    localparam logic [IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [IDX_W-1:0] REG_WIDTH     = 2'd1;
    localparam logic [IDX_W-1:0] REG_HEIGHT    = 2'd2;

    localparam logic [CFG_W-1:0] THRESHOLD_RST = 11'd20;
    localparam logic [CFG_W-1:0] WIDTH_RST     = 11'd320;
    localparam logic [CFG_W-1:0] HEIGHT_RST    = 11'd480;
    localparam logic [CFG_W-1:0] MIN_SIZE      = 11'd2;
    localparam logic [CFG_W-1:0] MAX_HEIGHT    = 11'd1024;

    // one output word, depth in the lowest bits
    typedef struct packed {
        logic                 last;
        logic [OUT_COL_W-1:0] col;
        logic [ROW_W-1:0]     row;
        logic [DEPTH_W-1:0]   depth;
    } result_t;

    function automatic logic [SUM_W-1:0] label_sum(input logic [LABEL_W-1:0] lab);
        return SUM_W'(lab[7:0]) + SUM_W'(lab[15:8]) + SUM_W'(lab[23:16]);
    endfunction

endpackage

@@ rtl/lebd_line_buf.sv @@
// Previous-row line memories for label, depth and edge flags, with registered reads.
module lebd_line_buf #(
    parameter int MAX_WIDTH = 1024,
    parameter int COL_W     = 10
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  logic [COL_W-1:0]              rd_addr,
    input  logic [COL_W-1:0]              rd_addr_next,
    input  logic [lebd_pkg::LABEL_W-1:0]  wr_label,
    input  logic [lebd_pkg::DEPTH_W-1:0]  wr_depth,
    input  logic                          flag_we,
    input  logic [COL_W-1:0]              flag_waddr,
    input  logic                          flag_wdata,
    output logic [lebd_pkg::LABEL_W-1:0]  lab_c,
    output logic [lebd_pkg::LABEL_W-1:0]  lab_c1,
    output logic [lebd_pkg::DEPTH_W-1:0]  dep_c,
    output logic                          flag_c
);

    logic [lebd_pkg::LABEL_W-1:0] label_mem [MAX_WIDTH];
    logic [lebd_pkg::DEPTH_W-1:0] depth_mem [MAX_WIDTH];
    logic                         flag_mem  [MAX_WIDTH];

    logic [lebd_pkg::LABEL_W-1:0] lab_c_reg;
    logic [lebd_pkg::LABEL_W-1:0] lab_c1_reg;
    logic [lebd_pkg::DEPTH_W-1:0] dep_c_reg;
    logic                         flag_c_reg;
    // flags are written column by column from zero, so written entries form a prefix
    logic [COL_W:0]               fill_reg;
    logic [COL_W:0]               fill_next;
    logic [COL_W:0]               flag_top;

    assign flag_top = {1'b0, flag_waddr} + (COL_W+1)'(1);

    always_comb begin
        fill_next = fill_reg;
        if (flag_we && (flag_top > fill_reg)) begin
            fill_next = flag_top;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            lab_c_reg  <= label_mem[rd_addr];
            lab_c1_reg <= label_mem[rd_addr_next];
            dep_c_reg  <= depth_mem[rd_addr];
            flag_c_reg <= flag_mem[rd_addr] & ({1'b0, rd_addr} < fill_reg);
            label_mem[rd_addr] <= wr_label;
            depth_mem[rd_addr] <= wr_depth;
        end
    end

    always_ff @(posedge aclk) begin
        if (flag_we) begin
            flag_mem[flag_waddr] <= flag_wdata;
        end
    end

    assign lab_c  = lab_c_reg;
    assign lab_c1 = lab_c1_reg;
    assign dep_c  = dep_c_reg;
    assign flag_c = flag_c_reg;

endmodule

@@ rtl/lebd_edge_unit.sv @@
// Edge test on the 2x2 anchor, cover logic and output word register.
module lebd_edge_unit #(
    parameter int COL_W = 10
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s1_valid,
    input  logic [lebd_pkg::LABEL_W-1:0]  s1_label,
    input  logic [lebd_pkg::DEPTH_W-1:0]  s1_depth,
    input  logic [lebd_pkg::ROW_W-1:0]    s1_row,
    input  logic [COL_W-1:0]              s1_col,
    input  logic [lebd_pkg::LABEL_W-1:0]  lab_c,
    input  logic [lebd_pkg::LABEL_W-1:0]  lab_c1,
    input  logic [lebd_pkg::DEPTH_W-1:0]  dep_c,
    input  logic                          flag_c,
    input  logic [lebd_pkg::CFG_W-1:0]    threshold,
    input  logic [COL_W:0]                width,
    input  logic [lebd_pkg::CFG_W-1:0]    height,
    output logic                          s1_done,
    output logic                          flag_we,
    output logic [COL_W-1:0]              flag_waddr,
    output logic                          flag_wdata,
    output logic                          m_valid,
    input  logic                          m_ready,
    output lebd_pkg::result_t             m_result
);

    localparam int WW = COL_W + 1;

    logic                        phase_reg;
    logic                        phase_next;
    logic [1:0]                  prev_flags_reg;
    logic [1:0]                  prev_flags_next;
    logic                        m_valid_reg;
    logic                        m_valid_next;
    lebd_pkg::result_t           m_data_reg;
    lebd_pkg::result_t           m_data_next;

    logic [lebd_pkg::OUT_COL_W-1:0] col_out;
    logic [WW-1:0]               col_inc;
    logic                        has_up;
    logic                        has_cur;
    logic                        out_ok;
    logic                        emit;
    logic [lebd_pkg::CFG_W-1:0]  s_centre;
    logic [lebd_pkg::CFG_W-1:0]  s_other;
    logic signed [lebd_pkg::CFG_W:0] diff;
    logic [lebd_pkg::CFG_W-1:0]  mag;
    logic                        anchor;
    logic                        old_flag;
    logic [1:0]                  pf;
    logic                        cover_up;
    logic                        cover_cur;

    generate
        if (COL_W >= lebd_pkg::OUT_COL_W) begin : g_col_trunc
            assign col_out = s1_col[lebd_pkg::OUT_COL_W-1:0];
        end else begin : g_col_ext
            assign col_out = {{(lebd_pkg::OUT_COL_W-COL_W){1'b0}}, s1_col};
        end
    endgenerate

    assign col_inc  = {1'b0, s1_col} + WW'(1);
    assign has_up   = (s1_row != '0);
    assign has_cur  = has_up && ((lebd_pkg::CFG_W'(s1_row) + lebd_pkg::CFG_W'(1)) == height);
    assign out_ok   = !m_valid_reg || m_ready;
    assign emit     = s1_valid && has_up && out_ok;
    assign s1_done  = s1_valid && (!has_up || (out_ok && (phase_reg || !has_cur)));

    // centre counted twice against right plus down
    assign s_centre = {lebd_pkg::label_sum(lab_c), 1'b0};
    assign s_other  = lebd_pkg::CFG_W'(lebd_pkg::label_sum(lab_c1))
                    + lebd_pkg::CFG_W'(lebd_pkg::label_sum(s1_label));
    assign diff     = $signed({1'b0, s_other}) - $signed({1'b0, s_centre});
    assign mag      = diff[lebd_pkg::CFG_W] ? lebd_pkg::CFG_W'(-diff)
                                            : diff[lebd_pkg::CFG_W-1:0];
    assign anchor   = (col_inc < width) && (mag >= threshold);
    assign old_flag = flag_c && (s1_row >= lebd_pkg::ROW_W'(2));
    assign pf       = (s1_col == '0) ? 2'b00 : prev_flags_reg;
    assign cover_up  = old_flag | anchor | pf[0] | pf[1];
    assign cover_cur = anchor | pf[0];

    always_comb begin
        phase_next      = phase_reg;
        prev_flags_next = prev_flags_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        if (s1_done) begin
            phase_next      = 1'b0;
            prev_flags_next = has_up ? {old_flag, anchor} : pf;
        end else if (emit) begin
            phase_next = 1'b1;
        end
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next.col = col_out;
            if (!phase_reg) begin
                m_data_next.depth = cover_up ? '0 : dep_c;
                m_data_next.row   = s1_row - lebd_pkg::ROW_W'(1);
                m_data_next.last  = 1'b0;
            end else begin
                m_data_next.depth = cover_cur ? '0 : s1_depth;
                m_data_next.row   = s1_row;
                m_data_next.last  = (col_inc == width);
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= 1'b0;
            prev_flags_reg <= 2'b00;
            m_valid_reg    <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            prev_flags_reg <= prev_flags_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign flag_we    = s1_done && has_up;
    assign flag_waddr = s1_col;
    assign flag_wdata = anchor;
    assign m_valid    = m_valid_reg;
    assign m_result   = m_data_reg;

endmodule

@@ rtl/label_edge_depth_blanker_top.sv @@
// Label edge depth blanker: top level with configuration, raster counters and input stage.
//
// Pixels arrive in raster order, at most one word per cycle. Each anchor pixel whose
// right and lower neighbours differ in summed label colour from twice its own
// sum by at least the threshold blanks the depth of its 2x2 square. Depth of
// row r-1 leaves while row r arrives; the first row produces no words and the
// last row produces two words per pixel (the pixel above, then the pixel
// itself). Throughput is one pixel per cycle when m_tready does not stall,
// lower on the last row where the single output register is the limit.
// Each accepted input word is held in the input stage register, and its
// output word is then registered in the output register; on the last row the
// second word follows the first. Three line memories of MAX_WIDTH entries hold
// the previous row. Size registers are clamped to 2..MAX_WIDTH and 2..1024;
// change configuration only while the block is idle.
module label_edge_depth_blanker_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // label_ch0[7:0], label_ch1[15:8], label_ch2[23:16], depth_in[39:24]
    input  logic [lebd_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // depth_out[15:0], out_row[25:16], out_col[35:26], zero pad[39:36]
    output logic [lebd_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                               m_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lebd_pkg::IDX_W-1:0]         cfg_index,
    input  logic [lebd_pkg::CFG_W-1:0]         cfg_data
);

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW    = COL_W + 1;

    logic [lebd_pkg::CFG_W-1:0]   thr_reg;
    logic [lebd_pkg::CFG_W-1:0]   width_reg;
    logic [lebd_pkg::CFG_W-1:0]   height_reg;
    logic [WW-1:0]                w_eff;
    logic [lebd_pkg::CFG_W-1:0]   h_eff;

    logic [COL_W-1:0]             col_reg;
    logic [COL_W-1:0]             col_next;
    logic [lebd_pkg::ROW_W-1:0]   row_reg;
    logic [lebd_pkg::ROW_W-1:0]   row_next;
    logic [COL_W-1:0]             c_in;
    logic [lebd_pkg::ROW_W-1:0]   r_in;
    logic [WW-1:0]                c_inc;
    logic [lebd_pkg::CFG_W-1:0]   r_inc;

    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    logic [lebd_pkg::LABEL_W-1:0] s1_label_reg;
    logic [lebd_pkg::DEPTH_W-1:0] s1_depth_reg;
    logic [lebd_pkg::ROW_W-1:0]   s1_row_reg;
    logic [COL_W-1:0]             s1_col_reg;

    logic                         acc;
    logic                         s1_done;
    logic [lebd_pkg::LABEL_W-1:0] lab_c;
    logic [lebd_pkg::LABEL_W-1:0] lab_c1;
    logic [lebd_pkg::DEPTH_W-1:0] dep_c;
    logic                         flag_c;
    logic                         flag_we;
    logic [COL_W-1:0]             flag_waddr;
    logic                         flag_wdata;
    lebd_pkg::result_t            result;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg    <= lebd_pkg::THRESHOLD_RST;
            width_reg  <= lebd_pkg::WIDTH_RST;
            height_reg <= lebd_pkg::HEIGHT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                lebd_pkg::REG_THRESHOLD: thr_reg    <= cfg_data;
                lebd_pkg::REG_WIDTH:     width_reg  <= cfg_data;
                lebd_pkg::REG_HEIGHT:    height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (width_reg < lebd_pkg::MIN_SIZE) begin
            w_eff = WW'(2);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(width_reg);
        end
        if (height_reg < lebd_pkg::MIN_SIZE) begin
            h_eff = lebd_pkg::MIN_SIZE;
        end else if (height_reg > lebd_pkg::MAX_HEIGHT) begin
            h_eff = lebd_pkg::MAX_HEIGHT;
        end else begin
            h_eff = height_reg;
        end
    end

    // raster position
    assign s_tready = !s1_valid_reg || s1_done;
    assign acc      = s_tvalid && s_tready;
    assign c_in     = ({1'b0, col_reg} >= w_eff) ? '0 : col_reg;
    assign r_in     = (lebd_pkg::CFG_W'(row_reg) >= h_eff) ? '0 : row_reg;
    assign c_inc    = {1'b0, c_in} + WW'(1);
    assign r_inc    = lebd_pkg::CFG_W'(r_in) + lebd_pkg::CFG_W'(1);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (acc) begin
            if (c_inc >= w_eff) begin
                col_next = '0;
                row_next = (r_inc >= h_eff) ? '0 : r_inc[lebd_pkg::ROW_W-1:0];
            end else begin
                col_next = c_inc[COL_W-1:0];
                row_next = r_in;
            end
        end
    end

    assign s1_valid_next = acc ? 1'b1 : (s1_done ? 1'b0 : s1_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            s1_label_reg <= s_tdata[23:0];
            s1_depth_reg <= s_tdata[39:24];
            s1_row_reg   <= r_in;
            s1_col_reg   <= c_in;
        end
    end

    lebd_line_buf #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_line_buf (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .rd_en        (acc),
        .rd_addr      (c_in),
        .rd_addr_next (c_inc[COL_W-1:0]),
        .wr_label     (s_tdata[23:0]),
        .wr_depth     (s_tdata[39:24]),
        .flag_we      (flag_we),
        .flag_waddr   (flag_waddr),
        .flag_wdata   (flag_wdata),
        .lab_c        (lab_c),
        .lab_c1       (lab_c1),
        .dep_c        (dep_c),
        .flag_c       (flag_c)
    );

    lebd_edge_unit #(
        .COL_W (COL_W)
    ) u_edge_unit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s1_valid   (s1_valid_reg),
        .s1_label   (s1_label_reg),
        .s1_depth   (s1_depth_reg),
        .s1_row     (s1_row_reg),
        .s1_col     (s1_col_reg),
        .lab_c      (lab_c),
        .lab_c1     (lab_c1),
        .dep_c      (dep_c),
        .flag_c     (flag_c),
        .threshold  (thr_reg),
        .width      (w_eff),
        .height     (h_eff),
        .s1_done    (s1_done),
        .flag_we    (flag_we),
        .flag_waddr (flag_waddr),
        .flag_wdata (flag_wdata),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_result   (result)
    );

    assign m_tdata = {4'b0000, result.col, result.row, result.depth};
    assign m_tlast = result.last;

endmodule
